// ===== src/kinl_pkg.sv =====
// ----------------------------------------------------------------------------
// kinl_pkg: shared types, constants and helpers for the lexer
// Token kinds, scan modes, keyword tables and character classification.
// ----------------------------------------------------------------------------
package kinl_pkg;

   // Widths and limits
   localparam int OFFSET_BITS   = 32;
   localparam int MAX_TOKEN_LEN = 255;
   localparam int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1);
   localparam int NUM_KW        = 3;
   localparam int MAX_RESULTS   = 3;
   localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);

   // Scan modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_EQUAL,
      MODE_DONE
   } mode_type;

   // Token kind codes
   typedef enum logic [3:0] {
      KIND_IDENT  = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_LET    = 4'd2,
      KIND_PRINT  = 4'd3,
      KIND_WHILE  = 4'd4,
      KIND_PLUS   = 4'd5,
      KIND_MINUS  = 4'd6,
      KIND_MUL    = 4'd7,
      KIND_DIV    = 4'd8,
      KIND_ASSIGN = 4'd9,
      KIND_EQ     = 4'd10,
      KIND_SEMI   = 4'd11,
      KIND_LT     = 4'd12,
      KIND_LBRACE = 4'd13,
      KIND_RBRACE = 4'd14,
      KIND_END    = 4'd15
   } kind_type;

   // One result token
   typedef struct packed {
      kind_type                kind;
      logic [OFFSET_BITS-1:0]  offset;
      logic [LEN_BITS-1:0]     length;
   } token_type;

   // Characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_SEMI   = ";";
   localparam logic [7:0] CH_LESS   = "<";
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_RBRACE = "}";

   // Keyword table: let, print, while (padded to eight characters)
   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
   };
   localparam int       KW_LEN  [NUM_KW] = '{3, 5, 5};
   localparam kind_type KW_KIND [NUM_KW] = '{KIND_LET, KIND_PRINT, KIND_WHILE};

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Drop keywords that no longer match at character position idx
   function automatic logic [NUM_KW-1:0] narrow_cand(input logic [NUM_KW-1:0] cand,
                                                     input logic [LEN_BITS-1:0] idx,
                                                     input logic [7:0] c);
      logic [NUM_KW-1:0] r;
      r = cand;
      for (int k = 0; k < NUM_KW; k++) begin
         if ((idx >= LEN_BITS'(KW_LEN[k])) || (KW_TEXT[k][idx[2:0]] != c)) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   // A mode that holds an unfinished token
   function automatic logic is_pending(input mode_type mode);
      return (mode == MODE_IDENT) || (mode == MODE_NUMBER) || (mode == MODE_EQUAL);
   endfunction

   // Token produced when the pending token is closed
   function automatic token_type flush_tok(input mode_type mode,
                                           input logic [OFFSET_BITS-1:0] start,
                                           input logic [LEN_BITS-1:0] len,
                                           input logic [NUM_KW-1:0] cand);
      token_type t;
      t.offset = start;
      t.length = len;
      t.kind   = KIND_IDENT;
      case (mode)
         MODE_IDENT: begin
            for (int k = 0; k < NUM_KW; k++) begin
               if (cand[k] && (len == LEN_BITS'(KW_LEN[k]))) begin
                  t.kind = KW_KIND[k];
               end
            end
         end
         MODE_NUMBER: begin
            t.kind = KIND_NUMBER;
         end
         MODE_EQUAL: begin
            t.kind   = KIND_ASSIGN;
            t.length = LEN_BITS'(1);
         end
         default: begin
            t.kind = KIND_IDENT;
         end
      endcase
      return t;
   endfunction

endpackage

// ===== src/keyword_identifier_number_lexer.sv =====
// ----------------------------------------------------------------------------
// keyword_identifier_number_lexer: byte-serial tokenizer
// Scans identifiers, keywords, numbers and operators and reports each token
// as kind, start offset and length.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  source_byte, end_of_source
//   rsp      out        rsp_valid/rsp_ready  token_kind, token_offset,
//                                            token_length, last_of_run
//
// One request is taken per cycle while each byte yields at most one token and
// rsp_ready stays high. A byte that yields k tokens (k up to 3) holds the result
// group register until all k have left; the port drains one token per ready cycle.
// req_ready is high when the group register is empty or its last token
// leaves in this cycle. Synchronous reset returns the scanner to idle at
// offset zero. A stalled response holds the group and drops req_ready.
//
module keyword_identifier_number_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [31:0] rsp_token_offset,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_last_of_run
);
   import kinl_pkg::*;

   // Scanner state
   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [NUM_KW-1:0]      cand_ff, cand_in;

   // Result group
   token_type              grp_ff [MAX_RESULTS];
   token_type              grp_in [MAX_RESULTS];
   logic [CNT_BITS-1:0]    grp_cnt_ff, grp_cnt_in;

   // Per-byte events
   mode_type               mid_mode;
   logic                   byte_used;
   logic                   flush_a_v, flush_b_v, single_v, end_v;
   kind_type               single_kind;
   logic [OFFSET_BITS-1:0] single_off, end_off, pos_inc;
   logic [LEN_BITS-1:0]    single_len;
   logic                   op_v;
   kind_type               op_kind;
   logic                   byte_alpha, byte_digit;
   logic                   accept, pop;

   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (grp_cnt_ff == '0) || (pop && (grp_cnt_ff == CNT_BITS'(1)));
   assign accept    = req_valid && req_ready;

   assign byte_alpha = is_alpha(req_source_byte);
   assign byte_digit = is_digit(req_source_byte);
   assign pos_inc    = pos_ff + OFFSET_BITS'(1);

   // Single-character operators
   always_comb begin
      op_v    = 1'b1;
      op_kind = KIND_PLUS;
      case (req_source_byte)
         CH_PLUS:   op_kind = KIND_PLUS;
         CH_MINUS:  op_kind = KIND_MINUS;
         CH_STAR:   op_kind = KIND_MUL;
         CH_SLASH:  op_kind = KIND_DIV;
         CH_SEMI:   op_kind = KIND_SEMI;
         CH_LESS:   op_kind = KIND_LT;
         CH_LBRACE: op_kind = KIND_LBRACE;
         CH_RBRACE: op_kind = KIND_RBRACE;
         default:   op_v    = 1'b0;
      endcase
   end

   // Next state and token events for the incoming byte
   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      cand_in     = cand_ff;
      mid_mode    = mode_ff;
      byte_used   = 1'b0;
      flush_a_v   = 1'b0;
      flush_b_v   = 1'b0;
      single_v    = 1'b0;
      single_kind = op_kind;
      single_off  = pos_ff;
      single_len  = LEN_BITS'(1);
      end_v       = 1'b0;
      end_off     = pos_ff;
      case (mode_ff)
         MODE_DONE: begin
            // only the end marker leaves this mode
            if (req_end_of_source) begin
               mode_in = MODE_IDLE;
               pos_in  = '0;
            end
         end
         default: begin
            if (req_source_byte == CH_NUL) begin
               // zero byte: flush, then END at this byte's offset
               flush_a_v = is_pending(mode_ff);
               end_v     = 1'b1;
               if (req_end_of_source) begin
                  mode_in = MODE_IDLE;
                  pos_in  = '0;
               end else begin
                  mode_in = MODE_DONE;
               end
            end else begin
               // continue or close the pending token
               case (mode_ff)
                  MODE_EQUAL: begin
                     if (req_source_byte == CH_EQUAL) begin
                        single_v    = 1'b1;
                        single_kind = KIND_EQ;
                        single_off  = start_ff;
                        single_len  = LEN_BITS'(2);
                        mid_mode    = MODE_IDLE;
                        byte_used   = 1'b1;
                     end else begin
                        flush_a_v = 1'b1;
                        mid_mode  = MODE_IDLE;
                     end
                  end
                  MODE_IDENT: begin
                     if (byte_alpha || byte_digit) begin
                        cand_in   = narrow_cand(cand_ff, len_ff, req_source_byte);
                        byte_used = 1'b1;
                        if (len_ff < LEN_BITS'(MAX_TOKEN_LEN)) begin
                           len_in = len_ff + LEN_BITS'(1);
                        end
                     end else begin
                        flush_a_v = 1'b1;
                        mid_mode  = MODE_IDLE;
                     end
                  end
                  MODE_NUMBER: begin
                     if (byte_digit) begin
                        byte_used = 1'b1;
                        if (len_ff < LEN_BITS'(MAX_TOKEN_LEN)) begin
                           len_in = len_ff + LEN_BITS'(1);
                        end
                     end else begin
                        flush_a_v = 1'b1;
                        mid_mode  = MODE_IDLE;
                     end
                  end
                  default: begin
                     mid_mode = MODE_IDLE;
                  end
               endcase

               // start a new token with this byte
               if (!byte_used) begin
                  if (byte_alpha) begin
                     mid_mode = MODE_IDENT;
                     start_in = pos_ff;
                     len_in   = LEN_BITS'(1);
                     cand_in  = narrow_cand('1, '0, req_source_byte);
                  end else if (byte_digit) begin
                     mid_mode = MODE_NUMBER;
                     start_in = pos_ff;
                     len_in   = LEN_BITS'(1);
                  end else if (req_source_byte == CH_EQUAL) begin
                     mid_mode = MODE_EQUAL;
                     start_in = pos_ff;
                     len_in   = LEN_BITS'(1);
                  end else begin
                     single_v = op_v;
                     mid_mode = MODE_IDLE;
                  end
               end

               // end of source flushes and restarts
               if (req_end_of_source) begin
                  flush_b_v = is_pending(mid_mode);
                  end_v     = 1'b1;
                  end_off   = pos_inc;
                  mode_in   = MODE_IDLE;
                  pos_in    = '0;
               end else begin
                  mode_in = mid_mode;
                  pos_in  = pos_inc;
               end
            end
         end
      endcase
   end

   // Pack the byte's tokens into the group, in order
   always_comb begin
      logic [CNT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         grp_in[i] = '0;
      end
      if (flush_a_v) begin
         grp_in[n] = flush_tok(mode_ff, start_ff, len_ff, cand_ff);
         n = n + CNT_BITS'(1);
      end
      if (single_v) begin
         grp_in[n] = '{kind: single_kind, offset: single_off, length: single_len};
         n = n + CNT_BITS'(1);
      end
      if (flush_b_v) begin
         grp_in[n] = flush_tok(mid_mode, start_in, len_in, cand_in);
         n = n + CNT_BITS'(1);
      end
      if (end_v) begin
         grp_in[n] = '{kind: KIND_END, offset: end_off, length: '0};
         n = n + CNT_BITS'(1);
      end
      grp_cnt_in = n;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pos_ff     <= '0;
         start_ff   <= '0;
         len_ff     <= '0;
         cand_ff    <= '1;
         grp_cnt_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            pos_ff     <= pos_in;
            start_ff   <= start_in;
            len_ff     <= len_in;
            cand_ff    <= cand_in;
            grp_cnt_ff <= grp_cnt_in;
         end else if (pop) begin
            grp_cnt_ff <= grp_cnt_ff - CNT_BITS'(1);
         end
      end
   end

   // Result group payload: load on request, shift toward slot 0 on pop
   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff <= grp_in;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            grp_ff[i] <= grp_ff[i+1];
         end
      end
   end

   assign rsp_valid        = (grp_cnt_ff != '0);
   assign rsp_token_kind   = grp_ff[0].kind;
   assign rsp_token_offset = 32'(grp_ff[0].offset);
   assign rsp_token_length = 8'(grp_ff[0].length);
   assign rsp_last_of_run  = (grp_cnt_ff == CNT_BITS'(1));

   // End marker always closes the byte's group
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_token_kind == KIND_END)) |-> rsp_last_of_run)
      else $error("END token is not the last of its group");

   // Bytes after an early zero give no tokens
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (mode_ff == MODE_DONE)) |=> (grp_cnt_ff == '0))
      else $error("token produced while scanning is done");

   // End of source restarts the scanner at offset zero
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_source) |=> ((mode_ff == MODE_IDLE) && (pos_ff == '0)))
      else $error("scanner did not restart after end of source");

   // Last token taken with no new request empties the group
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_last_of_run && !req_valid) |=> !rsp_valid)
      else $error("group not empty after its last token left");

endmodule
